/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is held low.
`define U8U16_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define U8U16_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/u8u16_pkg.sv */
// Types, constants and byte-class/state tables of the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

    localparam int OUT_DEPTH = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        has_unit;
        logic        out_last;
    } t_out_item;

    typedef struct packed {
        logic [3:0]  dfa;
        logic [20:0] partial_code;
        logic        at_string_start;
    } t_dec_state;

    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_dec_out;

    localparam logic [3:0] ST_ACCEPT  = 4'd0;
    localparam logic [3:0] ST_REJECT  = 4'd1;
    localparam logic [3:0] NUM_STATES = 4'd9;
    localparam int         NUM_CLASSES = 12;

    localparam logic [3:0] CLS_ASCII    = 4'd0;
    localparam logic [3:0] CLS_CONT_LO  = 4'd1;
    localparam logic [3:0] CLS_LEAD2    = 4'd2;
    localparam logic [3:0] CLS_LEAD3    = 4'd3;
    localparam logic [3:0] CLS_ED       = 4'd4;
    localparam logic [3:0] CLS_F4       = 4'd5;
    localparam logic [3:0] CLS_LEAD4    = 4'd6;
    localparam logic [3:0] CLS_CONT_HI  = 4'd7;
    localparam logic [3:0] CLS_INVALID  = 4'd8;
    localparam logic [3:0] CLS_CONT_MID = 4'd9;
    localparam logic [3:0] CLS_E0       = 4'd10;
    localparam logic [3:0] CLS_F0       = 4'd11;

    localparam logic [15:0] REPL_CHAR    = 16'hFFFD;
    localparam logic [15:0] HI_SURR_BASE = 16'hD7C0;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [20:0] BOM_CODE     = 21'h00FEFF;
    localparam logic [20:0] BMP_LIMIT    = 21'h010000;
    localparam logic [20:0] CODE_MAX     = 21'h10FFFF;

    // Next state, indexed by state * NUM_CLASSES + class.
    localparam logic [3:0] NEXT_STATE [0:107] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
    };

    function automatic logic [3:0] byte_class(input logic [7:0] b);
        logic [3:0] cls;
        case (b) inside
            [8'h00:8'h7F]: cls = CLS_ASCII;
            [8'h80:8'h8F]: cls = CLS_CONT_LO;
            [8'h90:8'h9F]: cls = CLS_CONT_MID;
            [8'hA0:8'hBF]: cls = CLS_CONT_HI;
            [8'hC0:8'hC1]: cls = CLS_INVALID;
            [8'hC2:8'hDF]: cls = CLS_LEAD2;
            8'hE0:         cls = CLS_E0;
            8'hED:         cls = CLS_ED;
            [8'hE1:8'hEF]: cls = CLS_LEAD3;
            8'hF0:         cls = CLS_F0;
            [8'hF1:8'hF3]: cls = CLS_LEAD4;
            8'hF4:         cls = CLS_F4;
            default:       cls = CLS_INVALID;
        endcase
        return cls;
    endfunction

    function automatic logic [3:0] next_state(input logic [3:0] st, input logic [3:0] cls);
        logic [6:0] idx;
        idx = 7'(st) * 7'(NUM_CLASSES) + 7'(cls);
        return NEXT_STATE[idx];
    endfunction

endpackage

/* sv/u8u16_decode.sv */
// One decoder step: byte class, state transition, code point assembly and unit formation.
module u8u16_decode (
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    input  u8u16_pkg::t_dec_state  i_state,
    output u8u16_pkg::t_dec_state  o_state,
    output u8u16_pkg::t_dec_out    o_res
);

    logic [3:0]  w_st;
    logic [3:0]  w_cls;
    logic [3:0]  w_ns;
    logic [20:0] w_pc;
    logic        w_start;
    logic [1:0]  w_cnt;
    u8u16_pkg::t_out_item w_u0;
    u8u16_pkg::t_out_item w_u1;

    always_comb begin
        // Unused state codes behave as reject.
        w_st  = (i_state.dfa >= u8u16_pkg::NUM_STATES) ? u8u16_pkg::ST_REJECT : i_state.dfa;
        w_cls = u8u16_pkg::byte_class(i_byte);

        if (w_st != u8u16_pkg::ST_ACCEPT) begin
            w_pc = {i_state.partial_code[14:0], i_byte[5:0]};
        end else begin
            w_pc = {13'd0, (8'hFF >> w_cls) & i_byte};
        end

        w_ns    = u8u16_pkg::next_state(w_st, w_cls);
        w_start = i_state.at_string_start;
        w_cnt   = 2'd0;
        w_u0    = '0;
        w_u1    = '0;

        if (w_ns == u8u16_pkg::ST_ACCEPT) begin
            if (w_start && (w_pc == u8u16_pkg::BOM_CODE)) begin
                // drop leading byte-order mark
                w_cnt = 2'd0;
            end else if (w_pc < u8u16_pkg::BMP_LIMIT) begin
                w_u0  = '{code_unit: w_pc[15:0], has_unit: 1'b1, out_last: 1'b0};
                w_cnt = 2'd1;
            end else if (w_pc <= u8u16_pkg::CODE_MAX) begin
                w_u0 = '{code_unit: u8u16_pkg::HI_SURR_BASE + {5'd0, w_pc[20:10]},
                         has_unit: 1'b1, out_last: 1'b0};
                w_u1 = '{code_unit: u8u16_pkg::LO_SURR_BASE + {6'd0, w_pc[9:0]},
                         has_unit: 1'b1, out_last: 1'b0};
                w_cnt = 2'd2;
            end else begin
                w_u0  = '{code_unit: u8u16_pkg::REPL_CHAR, has_unit: 1'b1, out_last: 1'b0};
                w_cnt = 2'd1;
            end
            w_start = 1'b0;
        end else if (w_ns == u8u16_pkg::ST_REJECT) begin
            w_u0    = '{code_unit: u8u16_pkg::REPL_CHAR, has_unit: 1'b1, out_last: 1'b0};
            w_cnt   = 2'd1;
            w_start = 1'b0;
            w_ns    = u8u16_pkg::ST_ACCEPT;
        end

        o_state = '{dfa: w_ns, partial_code: w_pc, at_string_start: w_start};

        if (i_last) begin
            // An open sequence at the end emits nothing else, so it lands in the first slot.
            if (w_ns != u8u16_pkg::ST_ACCEPT) begin
                w_u0  = '{code_unit: u8u16_pkg::REPL_CHAR, has_unit: 1'b1, out_last: 1'b0};
                w_cnt = 2'd1;
            end
            if (w_cnt == 2'd0) begin
                w_u0  = '{code_unit: 16'd0, has_unit: 1'b0, out_last: 1'b0};
                w_cnt = 2'd1;
            end
            if (w_cnt == 2'd2) begin
                w_u1.out_last = 1'b1;
            end else begin
                w_u0.out_last = 1'b1;
            end
            o_state = '{dfa: u8u16_pkg::ST_ACCEPT, partial_code: 21'd0, at_string_start: 1'b1};
        end

        o_res = '{count: w_cnt, first: w_u0, second: w_u1};
    end

endmodule

/* sv/utf8_to_utf16_transcoder_unit.sv */
// Top level of the UTF-8 to UTF-16 transcoder: input register, decoder step, result queue.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------
//   in      | input     | i_in_valid / o_in_ready   | i_in_item  (in_byte, in_last)
//   out     | output    | o_out_valid / i_out_ready | o_out_item (code_unit, has_unit,
//           |           |                           |             out_last)
//
// One byte per cycle while the queue has room: a byte waits in the input register, and
// the decoder step writes its 0 to 2 code units into the OUT_DEPTH-entry result queue
// as the byte moves on. A result passes the input register and the result queue before
// it shows on o_out_valid. The result queue drains one unit per cycle while i_out_ready
// is high, so sustained input rate follows the output rate once surrogate pairs and end
// markers are counted; a byte moves on only while the queue has room for two units.
// Synchronous active-low reset clears the valid flag, decoder state and queue pointers.
module utf8_to_utf16_transcoder_unit #(
    parameter int OUT_DEPTH = u8u16_pkg::OUT_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  u8u16_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output u8u16_pkg::t_out_item  o_out_item
);

    localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic                  r_in_v;
    u8u16_pkg::t_in_item   r_in;
    u8u16_pkg::t_dec_state r_state;
    u8u16_pkg::t_dec_state n_state;
    u8u16_pkg::t_dec_out   w_res;

    u8u16_pkg::t_out_item  r_fifo [0:OUT_DEPTH-1];
    logic [PTR_W-1:0]      r_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr;
    logic [CNT_W-1:0]      r_cnt;
    logic [PTR_W-1:0]      n_wr_ptr;
    logic [PTR_W-1:0]      n_rd_ptr;
    logic [CNT_W-1:0]      n_cnt;
    logic [PTR_W-1:0]      w_wr1;
    logic [PTR_W-1:0]      w_wr2;
    logic [1:0]            w_push;
    logic                  w_pop;
    logic                  w_drain;

    u8u16_decode u_decode (
        .i_byte  (r_in.in_byte),
        .i_last  (r_in.in_last),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (w_res)
    );

    // Move the held byte on only while two queue slots are free.
    assign w_drain     = r_in_v && (r_cnt <= CNT_W'(OUT_DEPTH - 2));
    assign o_in_ready  = !r_in_v || w_drain;
    assign o_out_valid = (r_cnt != '0);
    assign o_out_item  = r_fifo[r_rd_ptr];
    assign w_pop       = o_out_valid && i_out_ready;
    assign w_push      = w_drain ? w_res.count : 2'd0;

    always_comb begin
        w_wr1 = (r_wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        w_wr2 = (w_wr1 == PTR_W'(OUT_DEPTH - 1)) ? '0 : w_wr1 + PTR_W'(1);
        case (w_push)
            2'd1:    n_wr_ptr = w_wr1;
            2'd2:    n_wr_ptr = w_wr2;
            default: n_wr_ptr = r_wr_ptr;
        endcase
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end else begin
            n_rd_ptr = r_rd_ptr;
        end
        n_cnt = r_cnt + CNT_W'(w_push) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v   <= 1'b0;
            r_state  <= '{dfa: u8u16_pkg::ST_ACCEPT, partial_code: 21'd0,
                          at_string_start: 1'b1};
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_v <= i_in_valid;
            end
            if (w_drain) begin
                r_state <= n_state;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (w_push != 2'd0) begin
            r_fifo[r_wr_ptr] <= w_res.first;
        end
        if (w_push == 2'd2) begin
            r_fifo[w_wr1] <= w_res.second;
        end
    end

endmodule

/* sv/u8u16_checker.sv */
// Port-level checks of the transcoder, bound to its top level.
`include "assert_macros.svh"

module u8u16_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input u8u16_pkg::t_in_item   i_in_item,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input u8u16_pkg::t_out_item  o_out_item
);

    // Hold a stalled input byte.
    `U8U16_ASSERT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item), "stalled input changed or dropped")

    // Hold a stalled result.
    `U8U16_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item), "stalled result changed or dropped")

    // Reset leaves no result pending.
    `U8U16_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid right after reset")

    // An empty marker always closes a string and carries no unit.
    `U8U16_ASSERT(a_empty_marker, i_clk, i_rst_n, o_out_valid && !o_out_item.has_unit |-> o_out_item.out_last && (o_out_item.code_unit == 16'd0), "malformed empty end marker")

    // A high surrogate is followed at once by its low surrogate.
    `U8U16_ASSERT(a_surr_pair, i_clk, i_rst_n, o_out_valid && i_out_ready && (o_out_item.code_unit[15:10] == 6'b110110) |-> !o_out_item.out_last ##1 o_out_valid && (o_out_item.code_unit[15:10] == 6'b110111), "high surrogate without low surrogate")

endmodule

bind utf8_to_utf16_transcoder_unit u8u16_checker u_u8u16_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
